@@ rtl/core/prt_pkg.sv @@
// Shared types and constants for the peer route table.
// Holds the controller state type, the command and status structs and the op codes.
// No dependencies.
`default_nettype none

package prt_pkg;

	// Operation codes carried by the op field.
	localparam logic [1:0] OP_ADD = 2'd0;
	localparam logic [1:0] OP_DST = 2'd1;
	localparam logic [1:0] OP_SRC = 2'd2;
	localparam logic [1:0] OP_BAD = 2'd3;

	localparam logic [7:0] OCTET_START = 8'd100;
	localparam logic [7:0] MCAST_LOW   = 8'd224;
	localparam logic [7:0] MCAST_HIGH  = 8'd239;
	localparam logic [4:0] INDEX_NONE  = 5'h1F;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_POST
	} prt_state_t;

	typedef struct packed {
		logic start;
		logic scan;
		logic finish;
		logic load_out;
	} prt_cmd_t;

	typedef struct packed {
		logic fin;
	} prt_stat_t;

endpackage

`default_nettype wire

@@ rtl/core/prt_ctrl.sv @@
// Controller state machine of the peer route table.
// Sequences accept, table scan and result hand-off; depends on prt_pkg.
`default_nettype none

module prt_ctrl
	import prt_pkg::*;
(
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      in_valid,
	output logic           in_ready,
	output logic           out_valid,
	input  wire logic      out_ready,
	input  wire prt_stat_t stat,
	output prt_cmd_t       cmd
);

	prt_state_t state_q;
	prt_state_t state_next;
	logic       out_valid_q;
	logic       out_free;

	assign out_free = !out_valid_q || out_ready;

	always_comb begin
		state_next = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) state_next = ST_SCAN;
			end
			ST_SCAN: begin
				if (stat.fin) state_next = ST_POST;
			end
			ST_POST: begin
				if (out_free) state_next = ST_IDLE;
			end
			default: state_next = ST_IDLE;
		endcase
	end

	always_comb begin
		in_ready     = 1'b0;
		cmd.start    = 1'b0;
		cmd.scan     = 1'b0;
		cmd.finish   = 1'b0;
		cmd.load_out = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready  = 1'b1;
				cmd.start = in_valid;
			end
			ST_SCAN: begin
				cmd.scan   = 1'b1;
				cmd.finish = stat.fin;
			end
			ST_POST: begin
				cmd.load_out = out_free;
			end
			default: begin
				in_ready = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_next;
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;

	a_accept_scans: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> (state_q == ST_SCAN))
		else $error("accepted item did not start a scan");

	a_finish_posts: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.finish |=> (state_q == ST_POST))
		else $error("finished scan did not move to result hand-off");

	a_load_shows: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_out |=> out_valid)
		else $error("loaded result is not presented");

	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(cmd.start && (cmd.finish || cmd.load_out)))
		else $error("new item started while another is still in flight");

endmodule

`default_nettype wire

@@ rtl/core/prt_datapath.sv @@
// Datapath of the peer route table: item registers, slot memory, scan counter,
// slot compare, result registers and configuration register; depends on prt_pkg.
`default_nettype none

module prt_datapath
	import prt_pkg::*;
#(
	parameter int TABLE_ENTRIES = 16
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire prt_cmd_t          cmd,
	output prt_stat_t              stat,
	input  wire logic              cfg_we,
	input  wire logic [31:0]       cfg_wdata,
	input  wire logic [1:0]        op,
	input  wire logic [31:0]       peer_id_hi,
	input  wire logic [63:0]       peer_id_lo,
	input  wire logic [31:0]       ip_addr,
	input  wire logic [15:0]       port_in,
	input  wire logic signed [4:0] index_in,
	output logic                   status,
	output logic [31:0]            out_ip,
	output logic [15:0]            port_out,
	output logic [31:0]            out_id_hi,
	output logic [63:0]            out_id_lo,
	output logic signed [4:0]      index_out,
	output logic [31:0]            own_ip
);

	localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
	localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_ENTRIES - 1);
	localparam logic [CNT_W-1:0] CNT_END  = CNT_W'(TABLE_ENTRIES);

	typedef struct packed {
		logic [95:0] id;
		logic [31:0] host;
		logic [31:0] dest;
		logic [15:0] port;
	} entry_t;

	typedef struct packed {
		logic        status;
		logic [31:0] ip;
		logic [15:0] port;
		logic [95:0] id;
		logic [4:0]  idx;
		logic [31:0] own;
	} result_t;

	// Bytes after the first zero byte of the ID read as zero.
	function automatic logic [95:0] norm_id(input logic [95:0] raw);
		logic [95:0] res;
		logic        seen;
		res  = raw;
		seen = 1'b0;
		for (int b = 11; b >= 0; b--) begin
			if (seen) begin
				res[b*8 +: 8] = 8'h00;
			end else if (raw[b*8 +: 8] == 8'h00) begin
				seen = 1'b1;
			end
		end
		return res;
	endfunction

	function automatic logic is_mcast(input logic [31:0] addr);
		return (addr[31:24] >= MCAST_LOW) && (addr[31:24] <= MCAST_HIGH);
	endfunction

	function automatic logic idx_in_range(input logic [4:0] idx);
		return !idx[4] && (32'(idx[3:0]) < TABLE_ENTRIES);
	endfunction

	// Item registers.
	logic [1:0]  op_q;
	logic [95:0] id_q;
	logic [31:0] ip_q;
	logic [15:0] port_q;
	logic [4:0]  idx_q;

	logic [31:0]             local_q;
	logic [7:0]              octet_q;
	logic [TABLE_ENTRIES-1:0] valid_q;

	logic [CNT_W-1:0] scan_cnt_q;
	logic             rd_pend_s1;
	logic [IDX_W-1:0] rd_idx_s1;
	entry_t           rd_entry_s1;
	entry_t           mem [TABLE_ENTRIES];

	logic    issue;
	logic    direct;
	logic    mcast;
	logic    id_ne;
	logic    slot_v;
	logic    id_match;
	logic    host_match;
	logic    decide;
	logic    fill;
	logic    upd;
	logic    quick;
	logic    mem_we;
	entry_t  wr_entry;
	result_t res;
	result_t res_q;

	assign issue      = cmd.scan && (scan_cnt_q < CNT_END);
	assign mcast      = is_mcast(ip_q);
	assign direct     = (op_q == OP_DST) && mcast && idx_in_range(idx_q);
	assign id_ne      = id_q[95:88] != 8'h00;
	assign slot_v     = valid_q[rd_idx_s1];
	assign id_match   = id_ne && (rd_entry_s1.id == id_q);
	assign host_match = rd_entry_s1.host == ip_q;
	assign quick      = (op_q == OP_BAD) || ((op_q == OP_SRC) && mcast);

	always_comb begin
		res        = '0;
		res.status = 1'b1;
		res.idx    = idx_q;
		decide     = 1'b0;
		fill       = 1'b0;
		upd        = 1'b0;
		case (op_q)
			OP_ADD: begin
				// Valid slots form a prefix, so the first empty slot ends the scan.
				if (!slot_v) begin
					decide     = 1'b1;
					fill       = 1'b1;
					res.status = 1'b0;
				end else if (id_match) begin
					decide     = 1'b1;
					upd        = 1'b1;
					res.status = 1'b0;
				end
			end
			OP_DST: begin
				if (direct) begin
					decide = 1'b1;
					if (slot_v) begin
						res.status = 1'b0;
						res.ip     = rd_entry_s1.dest;
						res.port   = rd_entry_s1.port;
						res.id     = rd_entry_s1.id;
					end else begin
						res.idx = INDEX_NONE;
					end
				end else if (slot_v && host_match) begin
					decide     = 1'b1;
					res.status = 1'b0;
					res.ip     = rd_entry_s1.dest;
					res.port   = rd_entry_s1.port;
					res.id     = rd_entry_s1.id;
					res.idx    = INDEX_NONE;
				end
			end
			OP_SRC: begin
				res.own = local_q;
				if (mcast) begin
					res.status = 1'b0;
				end else if (slot_v && id_match) begin
					decide     = 1'b1;
					res.status = 1'b0;
					res.ip     = rd_entry_s1.host;
					res.id     = rd_entry_s1.id;
				end
			end
			default: begin
				res.status = 1'b1;
			end
		endcase
	end

	assign stat.fin = quick || (rd_pend_s1 && (decide || (rd_idx_s1 == LAST_IDX)));
	assign mem_we   = cmd.finish && rd_pend_s1 && (fill || upd);

	always_comb begin
		if (fill) begin
			wr_entry = '{id: id_q, host: {local_q[31:8], octet_q}, dest: ip_q, port: port_q};
		end else begin
			wr_entry = '{id: rd_entry_s1.id, host: rd_entry_s1.host, dest: ip_q, port: port_q};
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) mem[rd_idx_s1] <= wr_entry;
		if (issue) rd_entry_s1 <= mem[scan_cnt_q[IDX_W-1:0]];
	end

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			op_q   <= op;
			id_q   <= norm_id({peer_id_hi, peer_id_lo});
			ip_q   <= ip_addr;
			port_q <= port_in;
			idx_q  <= index_in;
		end
		if (issue) rd_idx_s1 <= scan_cnt_q[IDX_W-1:0];
		if (cmd.finish) res_q <= res;
		if (cmd.load_out) begin
			status    <= res_q.status;
			out_ip    <= res_q.ip;
			port_out  <= res_q.port;
			out_id_hi <= res_q.id[95:64];
			out_id_lo <= res_q.id[63:0];
			index_out <= $signed(res_q.idx);
			own_ip    <= res_q.own;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			local_q    <= '0;
			octet_q    <= OCTET_START;
			valid_q    <= '0;
			scan_cnt_q <= '0;
			rd_pend_s1 <= 1'b0;
		end else begin
			if (cfg_we) begin
				local_q <= cfg_wdata;
				octet_q <= OCTET_START;
				valid_q <= '0;
			end else if (cmd.finish && rd_pend_s1 && fill) begin
				valid_q[rd_idx_s1] <= id_ne;
				octet_q            <= octet_q + 8'd1;
			end
			if (cmd.start) begin
				// A direct read starts at the requested slot and decides on it.
				if ((op == OP_DST) && is_mcast(ip_addr) && idx_in_range(index_in)) begin
					scan_cnt_q <= CNT_W'(index_in[3:0]);
				end else begin
					scan_cnt_q <= '0;
				end
				rd_pend_s1 <= 1'b0;
			end else begin
				if (issue) scan_cnt_q <= scan_cnt_q + CNT_W'(1);
				rd_pend_s1 <= issue;
			end
		end
	end

endmodule

`default_nettype wire

@@ rtl/core/peer_route_table.sv @@
// Peer route table: a table of TABLE_ENTRIES peers keyed by a 96-bit ID, filled in
// insertion order. Add updates a matching peer or fills the first empty slot with a
// host address built from local_address and a rolling last octet; destination and
// source queries look peers up by host address, by slot index or by ID. Each item is
// handled alone: the slot memory has one read port and the scan reads one slot per
// cycle; an unknown op or multicast source query ends the scan at once, a full scan
// reads every slot. A finished result sits in an output register, so the next item
// is taken while it waits. A write to local_address clears the table at once; the
// user must do it only while idle, and the block itself does not enforce this.
`default_nettype none

module peer_route_table
	import prt_pkg::*;
#(
	parameter int TABLE_ENTRIES = 16
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              cfg_we,
	input  wire logic [31:0]       cfg_wdata,
	input  wire logic              in_valid,
	output logic                   in_ready,
	input  wire logic [1:0]        op,
	input  wire logic [31:0]       peer_id_hi,
	input  wire logic [63:0]       peer_id_lo,
	input  wire logic [31:0]       ip_addr,
	input  wire logic [15:0]       port_in,
	input  wire logic signed [4:0] index_in,
	output logic                   out_valid,
	input  wire logic              out_ready,
	output logic                   status,
	output logic [31:0]            out_ip,
	output logic [15:0]            port_out,
	output logic [31:0]            out_id_hi,
	output logic [63:0]            out_id_lo,
	output logic signed [4:0]      index_out,
	output logic [31:0]            own_ip
);

	prt_cmd_t  cmd;
	prt_stat_t stat;

	prt_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	prt_datapath #(
		.TABLE_ENTRIES(TABLE_ENTRIES)
	) u_datapath (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.stat       (stat),
		.cfg_we     (cfg_we),
		.cfg_wdata  (cfg_wdata),
		.op         (op),
		.peer_id_hi (peer_id_hi),
		.peer_id_lo (peer_id_lo),
		.ip_addr    (ip_addr),
		.port_in    (port_in),
		.index_in   (index_in),
		.status     (status),
		.out_ip     (out_ip),
		.port_out   (port_out),
		.out_id_hi  (out_id_hi),
		.out_id_lo  (out_id_lo),
		.index_out  (index_out),
		.own_ip     (own_ip)
	);

endmodule

`default_nettype wire
